FILE: sv/zuq_pkg.sv
// Shared types and constants of the zooming uniform quantizer.
`default_nettype none
package zuq_pkg;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] sample;
        logic signed [31:0] decision_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quantized;
        logic [1:0]         zoom_action;
        logic [31:0]        step_size;
        logic [47:0]        scale_now;
        logic signed [15:0] zoom_level_now;
        logic [31:0]        zoom_out_total;
        logic [31:0]        zoom_in_total;
    } t_out_item;

    // Classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic        restart;
        logic        x_neg;
        logic [31:0] x_mag;
        logic [31:0] d_mag;
    } t_job;

    typedef struct packed {
        logic [4:0]  quant_bits;
        logic [31:0] full_scale;
        logic [17:0] shrink_factor;
        logic [17:0] grow_factor;
        logic [47:0] scale_floor;
        logic [47:0] scale_ceiling;
        logic [15:0] zoom_in_fraction;
        logic [15:0] dwell_steps;
    } t_cfg;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_OUT  = 2'd1;
    localparam logic [1:0] ACT_IN   = 2'd2;

    localparam logic [2:0] REG_QUANT_BITS   = 3'd0;
    localparam logic [2:0] REG_FULL_SCALE   = 3'd1;
    localparam logic [2:0] REG_SHRINK       = 3'd2;
    localparam logic [2:0] REG_GROW         = 3'd3;
    localparam logic [2:0] REG_FLOOR        = 3'd4;
    localparam logic [2:0] REG_CEILING      = 3'd5;
    localparam logic [2:0] REG_ZOOM_IN_FRAC = 3'd6;
    localparam logic [2:0] REG_DWELL        = 3'd7;

    localparam logic [4:0]  RST_QUANT_BITS = 5'd8;
    localparam logic [31:0] RST_FULL_SCALE = 32'd65536;
    localparam logic [17:0] RST_SHRINK     = 18'd32768;
    localparam logic [17:0] RST_GROW       = 18'd131072;
    localparam logic [47:0] RST_FLOOR      = 48'd17;
    localparam logic [47:0] RST_CEILING    = 48'd16777216000000;
    localparam logic [15:0] RST_ZI_FRAC    = 16'd6554;
    localparam logic [15:0] RST_DWELL      = 16'd5;

    localparam logic [47:0] SCALE_ONE   = 48'd16777216;
    localparam logic [4:0]  BITS_FALLBK = 5'd8;

    // Quotient bits of the step and magnitude divisions; larger results saturate.
    localparam int QUO_W  = 34;
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

endpackage
`default_nettype wire

FILE: sv/zooming_uniform_quantizer.sv
// Top level: configuration registers, front end, job queue and back end.
// A restart beat goes from the front-end register through the queue and the back end's done
// state to the output register; a quantize beat passes range, zoom decision, any scale update
// and up to three divider runs first. The back end takes one beat at a time, popping the next
// job only when idle again; the shared divider gives one quotient bit per cycle.
// The front end and a two-entry queue keep taking beats while the back end works.
// Reset (i_rst_n low, synchronous) restores register defaults, scale 1.0 and clears counters.
`default_nettype none
module zooming_uniform_quantizer #(
    parameter int MAX_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  zuq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output zuq_pkg::t_out_item  o_out_item,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [5:0]           paddr,
    input  wire [63:0]          pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import zuq_pkg::*;

    // Register file. Each register sits at an 8-byte slot since two of them are 48 bits wide.
    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    t_job       front_job;
    logic       front_valid;
    logic       front_ready;
    t_job       back_job;
    logic       back_valid;
    logic       back_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quant_bits       <= RST_QUANT_BITS;
            r_cfg.full_scale       <= RST_FULL_SCALE;
            r_cfg.shrink_factor    <= RST_SHRINK;
            r_cfg.grow_factor      <= RST_GROW;
            r_cfg.scale_floor      <= RST_FLOOR;
            r_cfg.scale_ceiling    <= RST_CEILING;
            r_cfg.zoom_in_fraction <= RST_ZI_FRAC;
            r_cfg.dwell_steps      <= RST_DWELL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_QUANT_BITS:   r_cfg.quant_bits       <= pwdata[4:0];
                REG_FULL_SCALE:   r_cfg.full_scale       <= pwdata[31:0];
                REG_SHRINK:       r_cfg.shrink_factor    <= pwdata[17:0];
                REG_GROW:         r_cfg.grow_factor      <= pwdata[17:0];
                REG_FLOOR:        r_cfg.scale_floor      <= pwdata[47:0];
                REG_CEILING:      r_cfg.scale_ceiling    <= pwdata[47:0];
                REG_ZOOM_IN_FRAC: r_cfg.zoom_in_fraction <= pwdata[15:0];
                default:          r_cfg.dwell_steps      <= pwdata[15:0];
            endcase
        end
    end

    // Read-back is combinational from the register file.
    always_comb begin
        unique case (reg_idx)
            REG_QUANT_BITS:   prdata = 64'(r_cfg.quant_bits);
            REG_FULL_SCALE:   prdata = 64'(r_cfg.full_scale);
            REG_SHRINK:       prdata = 64'(r_cfg.shrink_factor);
            REG_GROW:         prdata = 64'(r_cfg.grow_factor);
            REG_FLOOR:        prdata = 64'(r_cfg.scale_floor);
            REG_CEILING:      prdata = 64'(r_cfg.scale_ceiling);
            REG_ZOOM_IN_FRAC: prdata = 64'(r_cfg.zoom_in_fraction);
            default:          prdata = 64'(r_cfg.dwell_steps);
        endcase
    end

    // The front end registers each beat as a sign and magnitude job.
    zuq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    // The queue lets the front end keep accepting while the back end iterates.
    zuq_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_job   (front_job),
        .o_rd_valid (back_valid),
        .i_rd_pop   (back_pop),
        .o_rd_job   (back_job)
    );

    // The back end owns the scale, the zoom counters and the output register.
    zuq_back #(
        .MAX_BITS (MAX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (back_valid),
        .i_job       (back_job),
        .o_job_pop   (back_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

FILE: sv/zuq_front.sv
// Front end: takes request beats and turns them into sign and magnitude jobs.
`default_nettype none
module zuq_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  zuq_pkg::t_in_item   i_in_item,
    output logic                o_job_valid,
    output zuq_pkg::t_job       o_job,
    input  wire                 i_job_ready
);
    import zuq_pkg::*;

    logic r_valid;
    t_job r_job;
    t_job n_job;

    assign o_in_ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        n_job.restart = i_in_item.req_type;
        n_job.x_neg   = i_in_item.sample[31];
        n_job.x_mag   = i_in_item.sample[31] ? (~i_in_item.sample + 32'd1) : i_in_item.sample;
        n_job.d_mag   = i_in_item.decision_value[31] ?
                        (~i_in_item.decision_value + 32'd1) : i_in_item.decision_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

FILE: sv/zuq_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module zuq_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_wr_valid,
    output logic           o_wr_ready,
    input  zuq_pkg::t_job  i_wr_job,
    output logic           o_rd_valid,
    input  wire            i_rd_pop,
    output zuq_pkg::t_job  o_rd_job
);
    import zuq_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_job   = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

endmodule
`default_nettype wire

FILE: sv/zuq_back.sv
// Back end: range, zoom decision, scale update and the shared serial divider.
`default_nettype none
module zuq_back #(
    parameter int MAX_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  zuq_pkg::t_cfg       i_cfg,
    input  wire                 i_job_valid,
    input  zuq_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    output zuq_pkg::t_out_item  o_out_item,
    input  wire                 i_out_ready
);
    import zuq_pkg::*;

    localparam int LW = (MAX_BITS > 8) ? MAX_BITS : 8;
    localparam int DW = LW + 60;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RNG1 = 4'd1;
    localparam logic [3:0] S_RNG2 = 4'd2;
    localparam logic [3:0] S_ZI1  = 4'd3;
    localparam logic [3:0] S_ZI2  = 4'd4;
    localparam logic [3:0] S_SM1  = 4'd5;
    localparam logic [3:0] S_SM2  = 4'd6;
    localparam logic [3:0] S_KSET = 4'd7;
    localparam logic [3:0] S_KR1  = 4'd8;
    localparam logic [3:0] S_KR2  = 4'd9;
    localparam logic [3:0] S_SSET = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam logic [1:0] PH_K = 2'd0;
    localparam logic [1:0] PH_Q = 2'd1;
    localparam logic [1:0] PH_S = 2'd2;

    logic [3:0]        r_state;
    logic [1:0]        r_phase;
    t_job              r_job;
    logic [55:0]       r_rng;
    logic [63:0]       r_prod;
    logic [1:0]        r_act;
    logic [47:0]       r_ns;
    logic [DW-1:0]     r_num;
    logic [DW-1:0]     r_dd;
    logic [QUO_W-1:0]  r_quo;
    logic [5:0]        r_cnt;
    logic [LW-1:0]     r_k;
    logic [QUO_W-1:0]  r_qm;
    logic [QUO_W-1:0]  r_step;

    logic [47:0]        r_scale;
    logic signed [15:0] r_level;
    logic [31:0]        r_in_cnt;
    logic [31:0]        r_out_cnt;
    logic [15:0]        r_steps;

    logic               r_out_valid;
    t_out_item          r_out;

    logic [4:0]        bits_eff;
    logic [LW:0]       levels_w;
    logic [LW-1:0]     levels;
    logic [31:0]       m_eff;
    logic [55:0]       rng_lo;
    logic [55:0]       xc;
    logic [DW-1:0]     xcw;
    logic [DW-1:0]     num_k;
    logic [DW-1:0]     den2l;
    logic [63:0]       zi_full;
    logic              below;
    logic              grow_hit;
    logic [17:0]       factor;
    logic [33:0]       sm_lo;
    logic [50:0]       ns_full;
    logic [DW-1:0]     kr_hi;
    logic [DW-1:0]     set_num;
    logic              set_ovf;
    logic              ge;
    logic [QUO_W-1:0]  quo_nx;
    logic              slot_free;
    logic [QUO_W-1:0]  qm_c;
    logic [31:0]       q_val;
    logic [31:0]       step_val;
    logic              go_out;
    logic              go_in;

    assign bits_eff = (i_cfg.quant_bits == 5'd0 || int'(i_cfg.quant_bits) > MAX_BITS) ?
                      BITS_FALLBK : i_cfg.quant_bits;
    assign levels_w = ({{LW{1'b0}}, 1'b1} << bits_eff) - 1'b1;
    assign levels   = levels_w[LW-1:0];
    assign m_eff    = (i_cfg.full_scale == 32'd0) ? RST_FULL_SCALE : i_cfg.full_scale;
    assign rng_lo   = 56'(m_eff) * 56'(r_scale[23:0]);

    assign xc    = ({24'd0, r_job.x_mag} < r_rng) ? {24'd0, r_job.x_mag} : r_rng;
    assign xcw   = DW'(xc);
    assign num_k = (xcw << bits_eff) - xcw + DW'(r_rng);
    assign den2l = DW'({levels, 1'b0});

    assign zi_full  = ((64'(i_cfg.zoom_in_fraction) * 64'(r_rng[47:24])) << 24) + r_prod;
    assign below    = (i_cfg.zoom_in_fraction == 16'd0) ? 1'b0 :
                      (r_rng[55:48] != 8'd0) ? 1'b1 :
                      (64'({r_job.d_mag, 16'd0}) < zi_full);
    assign grow_hit = (64'(r_job.d_mag) * 64'd20) > (64'(r_rng) * 64'd19);

    assign factor  = (r_act == ACT_OUT) ? i_cfg.grow_factor : i_cfg.shrink_factor;
    assign sm_lo   = 34'(r_scale[15:0]) * 34'(factor);
    assign ns_full = r_prod[50:0] + 51'(sm_lo[33:16]);

    assign kr_hi   = DW'(r_k) * DW'(r_rng[55:28]);
    assign set_num = (r_state == S_KR2) ?
                     ((((kr_hi << 28) + DW'(r_prod)) << 2) + DW'(levels)) :
                     ((DW'(r_rng) << 2) + DW'(levels));
    assign set_ovf = (set_num >> QUO_W) >= den2l;

    assign ge     = (r_num >= r_dd);
    assign quo_nx = {r_quo[QUO_W-2:0], ge};

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign qm_c     = (r_qm > QUO_W'(33'h080000000)) ? QUO_W'(33'h080000000) : r_qm;
    assign q_val    = r_job.x_neg ? (~qm_c[31:0] + 32'd1) :
                      ((r_qm > QUO_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r_qm[31:0]);
    assign step_val = (r_step > QUO_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : r_step[31:0];
    assign go_out   = (r_act == ACT_OUT) && (r_ns <= i_cfg.scale_ceiling);
    assign go_in    = (r_act == ACT_IN) && (r_ns >= i_cfg.scale_floor);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The output register fills when a job retires and empties when its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= SCALE_ONE;
            r_level     <= '0;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_steps     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.restart ? S_DONE : S_RNG1;
                    end
                end
                S_RNG1: r_state <= S_RNG2;
                S_RNG2: r_state <= S_ZI1;
                S_ZI1:  r_state <= S_ZI2;
                S_ZI2: begin
                    if (grow_hit || (below && r_steps >= i_cfg.dwell_steps)) begin
                        r_state <= S_SM1;
                    end else begin
                        r_state <= S_KSET;
                    end
                end
                S_SM1:  r_state <= S_SM2;
                S_SM2:  r_state <= S_KSET;
                S_KSET: r_state <= (r_rng == 56'd0) ? S_DONE : S_DIV;
                S_KR1:  r_state <= S_KR2;
                S_KR2:  r_state <= set_ovf ? S_SSET : S_DIV;
                S_SSET: r_state <= set_ovf ? S_DONE : S_DIV;
                S_DIV: begin
                    if (r_cnt == 6'd1) begin
                        unique case (r_phase)
                            PH_K:    r_state <= S_KR1;
                            PH_Q:    r_state <= S_SSET;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state     <= S_IDLE;
                        if (r_job.restart) begin
                            r_scale   <= SCALE_ONE;
                            r_level   <= '0;
                            r_in_cnt  <= '0;
                            r_out_cnt <= '0;
                            r_steps   <= '0;
                        end else if (go_out || go_in) begin
                            r_scale <= r_ns;
                            r_steps <= 16'd1;
                            if (go_out) begin
                                if (r_level != 16'sh7FFF) r_level <= r_level + 16'sd1;
                                if (r_out_cnt != 32'hFFFFFFFF) r_out_cnt <= r_out_cnt + 32'd1;
                            end else begin
                                if (r_level != -16'sh8000) r_level <= r_level - 16'sd1;
                                if (r_in_cnt != 32'hFFFFFFFF) r_in_cnt <= r_in_cnt + 32'd1;
                            end
                        end else if (r_steps != 16'hFFFF) begin
                            r_steps <= r_steps + 16'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_act  <= ACT_NONE;
                r_qm   <= '0;
                r_step <= '0;
            end
            S_RNG1: r_prod <= 64'(m_eff) * 64'(r_scale[47:24]);
            S_RNG2: r_rng  <= r_prod[55:0] + 56'(rng_lo[55:24]);
            S_ZI1:  r_prod <= 64'(i_cfg.zoom_in_fraction) * 64'(r_rng[23:0]);
            S_ZI2: begin
                if (grow_hit) begin
                    r_act <= ACT_OUT;
                end else if (below && r_steps >= i_cfg.dwell_steps) begin
                    r_act <= ACT_IN;
                end
            end
            S_SM1:  r_prod <= 64'(r_scale[47:16]) * 64'(factor);
            S_SM2:  r_ns   <= (ns_full[50:48] != 3'd0) ? 48'hFFFFFFFFFFFF : ns_full[47:0];
            S_KSET: begin
                r_num   <= num_k;
                r_dd    <= DW'({r_rng, 1'b0}) << (LW - 1);
                r_cnt   <= 6'(LW);
                r_quo   <= '0;
                r_phase <= PH_K;
            end
            S_KR1:  r_prod <= 64'(r_k) * 64'(r_rng[27:0]);
            S_KR2, S_SSET: begin
                r_num   <= set_num;
                r_dd    <= den2l << (QUO_W - 1);
                r_cnt   <= 6'(QUO_W);
                r_quo   <= '0;
                r_phase <= (r_state == S_KR2) ? PH_Q : PH_S;
                if (set_ovf) begin
                    if (r_state == S_KR2) r_qm <= '1;
                    else r_step <= '1;
                end
            end
            S_DIV: begin
                if (ge) r_num <= r_num - r_dd;
                r_dd  <= r_dd >> 1;
                r_quo <= quo_nx;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    unique case (r_phase)
                        PH_K:    r_k    <= quo_nx[LW-1:0];
                        PH_Q:    r_qm   <= quo_nx;
                        default: r_step <= quo_nx;
                    endcase
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    r_out.quantized      <= r_job.restart ? 32'd0 : q_val;
                    r_out.zoom_action    <= r_job.restart ? ACT_NONE : r_act;
                    r_out.step_size      <= r_job.restart ? 32'd0 : step_val;
                    r_out.scale_now      <= r_job.restart ? SCALE_ONE :
                                            ((go_out || go_in) ? r_ns : r_scale);
                    r_out.zoom_level_now <= r_job.restart ? 16'sd0 :
                        (go_out && r_level != 16'sh7FFF) ? r_level + 16'sd1 :
                        (go_in && r_level != -16'sh8000) ? r_level - 16'sd1 : r_level;
                    r_out.zoom_out_total <= r_job.restart ? 32'd0 :
                        (go_out && r_out_cnt != 32'hFFFFFFFF) ? r_out_cnt + 32'd1 : r_out_cnt;
                    r_out.zoom_in_total  <= r_job.restart ? 32'd0 :
                        (go_in && r_in_cnt != 32'hFFFFFFFF) ? r_in_cnt + 32'd1 : r_in_cnt;
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

`ifndef SYNTHESIS
    a_restart_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && slot_free && r_job.restart)
        |=> (r_scale == SCALE_ONE && r_out_valid && r_out.zoom_action == ACT_NONE))
        else $error("restart did not restore the scale");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 6'd0))
        else $error("divider running with a zero iteration count");
    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && slot_free && !r_job.restart) |=> (r_steps != 16'd0))
        else $error("step counter zero after a quantize beat");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_zooming_uniform_quantizer.sv
// Self-checking testbench of the zooming uniform quantizer: directed table, then random beats.
`default_nettype none
module tb_zooming_uniform_quantizer;
    timeunit 1ns;
    timeprecision 1ps;
    import zuq_pkg::*;

    // Cycles without any accepted beat or register access before the run is declared hung.
    // The 87 percent stalls on either side stretch the time between accepted beats
    // several times over; this bound leaves a wide margin.
    localparam int HANG_LIMIT = 6000;
    // Cycles to wait after the last result.
    localparam int TAIL_CYCLES = 150;
    localparam int RANDOM_PER_PHASE = 86;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    zooming_uniform_quantizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers, as the block holds them.
    t_cfg shadow_cfg;

    // Shadow copy of the zoom state.
    logic [63:0]        zs_scale;
    logic signed [31:0] zs_level;
    logic [63:0]        zs_in_count;
    logic [63:0]        zs_out_count;
    logic [63:0]        zs_steps;

    // Results still owed by the block, oldest first.
    t_out_item pending_results[$];
    int        error_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        hang_count = 0;

    function automatic void clear_zoom_state();
        zs_scale = 64'(SCALE_ONE);
        zs_level = 0;
        zs_in_count = 0;
        zs_out_count = 0;
        zs_steps = 0;
    endfunction

    // Range in Q16.16 for the current scale and full scale, held at 64 bits.
    function automatic logic [63:0] current_range();
        logic [63:0] m;
        m = (shadow_cfg.full_scale == 0) ? 64'd65536 : 64'(shadow_cfg.full_scale);
        return m * (zs_scale >> 24) + ((m * (zs_scale & 64'hFF_FFFF)) >> 24);
    endfunction

    // Scale times a Q2.16 factor, saturated to 48 bits.
    function automatic logic [63:0] zoomed_scale(logic [63:0] s, logic [63:0] f);
        logic [63:0] r;
        r = (s >> 16) * f + (((s & 64'hFFFF) * f) >> 16);
        return (r > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : r;
    endfunction

    // Computes the result of one accepted beat and advances the shadow zoom state.
    function automatic t_out_item quantize_and_zoom(t_in_item beat);
        t_out_item   res;
        logic [63:0] bits, levels, range, xmag, dmag, xc, k, qm, stepv, ns;
        logic        xneg, below;
        res = '0;
        res.zoom_action = ACT_NONE;
        if (beat.req_type) begin
            clear_zoom_state();
        end else begin
            bits = 64'(shadow_cfg.quant_bits);
            if (bits == 0 || bits > 16) bits = 64'(BITS_FALLBK);
            levels = (64'd1 << bits) - 1;
            range = current_range();
            xneg = beat.sample[31];
            xmag = xneg ? (64'h1_0000_0000 - 64'(unsigned'(beat.sample)))
                        : 64'(unsigned'(beat.sample));
            dmag = beat.decision_value[31]
                 ? (64'h1_0000_0000 - 64'(unsigned'(beat.decision_value)))
                 : 64'(unsigned'(beat.decision_value));
            if (range != 0) begin
                xc = (xmag < range) ? xmag : range;
                k = (xc * levels + range) / (2 * range);
                qm = (4 * k * range + levels) / (2 * levels);
                if (xneg) begin
                    if (qm > 64'h8000_0000) qm = 64'h8000_0000;
                    res.quantized = 32'(64'h1_0000_0000 - qm);
                end else begin
                    res.quantized = (qm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(qm);
                end
                stepv = (4 * range + levels) / (2 * levels);
                res.step_size = (stepv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(stepv);
            end
            if (shadow_cfg.zoom_in_fraction == 0) below = 1'b0;
            else if (range >= (64'd1 << 48)) below = 1'b1;
            else below = (dmag << 16) < 64'(shadow_cfg.zoom_in_fraction) * range;

            if (20 * dmag > 19 * range) begin
                res.zoom_action = ACT_OUT;
                ns = zoomed_scale(zs_scale, 64'(shadow_cfg.grow_factor));
                if (ns <= 64'(shadow_cfg.scale_ceiling)) begin
                    zs_scale = ns;
                    if (zs_level < 32767) zs_level++;
                    if (zs_out_count < 64'hFFFF_FFFF) zs_out_count++;
                    zs_steps = 0;
                end
            end else if (below && zs_steps >= 64'(shadow_cfg.dwell_steps)) begin
                res.zoom_action = ACT_IN;
                ns = zoomed_scale(zs_scale, 64'(shadow_cfg.shrink_factor));
                if (ns >= 64'(shadow_cfg.scale_floor)) begin
                    zs_scale = ns;
                    if (zs_level > -32768) zs_level--;
                    if (zs_in_count < 64'hFFFF_FFFF) zs_in_count++;
                    zs_steps = 0;
                end
            end
            if (zs_steps < 65535) zs_steps++;
        end
        res.scale_now = 48'(zs_scale);
        res.zoom_level_now = 16'(zs_level);
        res.zoom_out_total = 32'(zs_out_count);
        res.zoom_in_total = 32'(zs_in_count);
        return res;
    endfunction

    // Directed rows carry a typed expectation only where it is obvious from the
    // register defaults; everything else goes through the shadow model.
    typedef struct {
        t_in_item  beat;
        bit        known;
        t_out_item result;
    } t_directed_row;

    t_directed_row directed_rows[$];
    // The expectation to use for the next accepted beat instead of the shadow model's.
    t_out_item typed_results[$];
    bit        typed_flags[$];

    // Input side: every accepted beat moves the shadow model forward.
    always @(posedge i_clk) begin
        t_out_item predicted;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predicted = quantize_and_zoom(i_in_item);
            if (typed_flags.size() > 0 && typed_flags.pop_front())
                predicted = typed_results.pop_front();
            pending_results.push_back(predicted);
        end
    end

    // Output side: compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.quantized !== want.quantized) begin
                    $error("quantized: expected %0d, got %0d",
                           want.quantized, o_out_item.quantized);
                    error_count++;
                end
                if (o_out_item.zoom_action !== want.zoom_action) begin
                    $error("zoom_action: expected %0d, got %0d",
                           want.zoom_action, o_out_item.zoom_action);
                    error_count++;
                end
                if (o_out_item.step_size !== want.step_size) begin
                    $error("step_size: expected %0d, got %0d",
                           want.step_size, o_out_item.step_size);
                    error_count++;
                end
                if (o_out_item.scale_now !== want.scale_now) begin
                    $error("scale_now: expected %0d, got %0d",
                           want.scale_now, o_out_item.scale_now);
                    error_count++;
                end
                if (o_out_item.zoom_level_now !== want.zoom_level_now) begin
                    $error("zoom_level_now: expected %0d, got %0d",
                           want.zoom_level_now, o_out_item.zoom_level_now);
                    error_count++;
                end
                if (o_out_item.zoom_out_total !== want.zoom_out_total) begin
                    $error("zoom_out_total: expected %0d, got %0d",
                           want.zoom_out_total, o_out_item.zoom_out_total);
                    error_count++;
                end
                if (o_out_item.zoom_in_total !== want.zoom_in_total) begin
                    $error("zoom_in_total: expected %0d, got %0d",
                           want.zoom_in_total, o_out_item.zoom_in_total);
                    error_count++;
                end
            end
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Hang detection: any beat or register access restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

    // One APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_QUANT_BITS:   shadow_cfg.quant_bits = value[4:0];
            REG_FULL_SCALE:   shadow_cfg.full_scale = value[31:0];
            REG_SHRINK:       shadow_cfg.shrink_factor = value[17:0];
            REG_GROW:         shadow_cfg.grow_factor = value[17:0];
            REG_FLOOR:        shadow_cfg.scale_floor = value[47:0];
            REG_CEILING:      shadow_cfg.scale_ceiling = value[47:0];
            REG_ZOOM_IN_FRAC: shadow_cfg.zoom_in_fraction = value[15:0];
            REG_DWELL:        shadow_cfg.dwell_steps = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(t_cfg c);
        write_reg(REG_QUANT_BITS, 64'(c.quant_bits));
        write_reg(REG_FULL_SCALE, 64'(c.full_scale));
        write_reg(REG_SHRINK, 64'(c.shrink_factor));
        write_reg(REG_GROW, 64'(c.grow_factor));
        write_reg(REG_FLOOR, 64'(c.scale_floor));
        write_reg(REG_CEILING, 64'(c.scale_ceiling));
        write_reg(REG_ZOOM_IN_FRAC, 64'(c.zoom_in_fraction));
        write_reg(REG_DWELL, 64'(c.dwell_steps));
    endtask

    // Waits until every owed result has come back, so the block is idle.
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Presents one beat and holds it until the block takes it. An idle gap lowers
    // valid for its whole length; back-to-back beats keep valid high and just swap
    // the payload.
    task automatic send_beat(t_in_item beat);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item <= beat;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random signed value of a given magnitude, clipped to the Q16.16 span.
    function automatic logic [31:0] signed_mag(logic [63:0] mag);
        logic [31:0] v;
        v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
        return $urandom_range(1) ? -v : v;
    endfunction

    // Random beats built around the current range so that both zoom directions
    // and the dwell counter are exercised, with a share of plain noise.
    function automatic t_in_item random_beat();
        t_in_item    b;
        logic [63:0] r, frac_mag;
        int          pick;
        r = current_range();
        b.req_type = ($urandom_range(99) < 4);
        pick = $urandom_range(9);
        case (pick)
            0: b.sample = $urandom();
            1: b.sample = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: b.sample = signed_mag(r + $urandom_range(3) - 1);
            default: b.sample = signed_mag((r * $urandom_range(1024)) >> 10);
        endcase
        frac_mag = (r * shadow_cfg.zoom_in_fraction) >> 16;
        pick = $urandom_range(9);
        case (pick)
            0, 1:    b.decision_value = $urandom();
            2:       b.decision_value = signed_mag((r * 19) / 20 + $urandom_range(2));
            3, 4:    b.decision_value = signed_mag(r + (r >> $urandom_range(1, 6)));
            default: b.decision_value = signed_mag(frac_mag > 0
                                                 ? $urandom_range(0, 32'(frac_mag))
                                                 : 0);
        endcase
        return b;
    endfunction

    function automatic t_directed_row row(logic req, logic [31:0] s, logic [31:0] d);
        t_directed_row rw;
        rw.beat.req_type = req;
        rw.beat.sample = s;
        rw.beat.decision_value = d;
        rw.known = 1'b0;
        rw.result = '0;
        return rw;
    endfunction

    function automatic t_directed_row known_row(logic req, logic [31:0] s, logic [31:0] d,
                                                t_out_item res);
        t_directed_row rw;
        rw = row(req, s, d);
        rw.known = 1'b1;
        rw.result = res;
        return rw;
    endfunction

    initial begin
        t_cfg settings[$];
        t_cfg c;
        int   phase;

        shadow_cfg.quant_bits = RST_QUANT_BITS;
        shadow_cfg.full_scale = RST_FULL_SCALE;
        shadow_cfg.shrink_factor = RST_SHRINK;
        shadow_cfg.grow_factor = RST_GROW;
        shadow_cfg.scale_floor = RST_FLOOR;
        shadow_cfg.scale_ceiling = RST_CEILING;
        shadow_cfg.zoom_in_fraction = RST_ZI_FRAC;
        shadow_cfg.dwell_steps = RST_DWELL;
        clear_zoom_state();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset defaults (8 bits, unit full scale, range 1.0).
        // A restart from reset gives all-zero counters and unit scale.
        directed_rows.push_back(known_row(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                '{0, ACT_NONE, 0, SCALE_ONE, 0, 0, 0}));
        // Zero sample, zero decision: no zoom yet since the dwell count is not met.
        directed_rows.push_back(known_row(1'b0, 32'd0, 32'd0,
                                '{0, ACT_NONE, 514, SCALE_ONE, 0, 0, 0}));
        // Largest sample clamps to the range; largest decision doubles the scale.
        directed_rows.push_back(known_row(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                '{65793, ACT_OUT, 514, 48'd33554432, 1, 1, 0}));
        directed_rows.push_back(row(1'b0, 32'h8000_0000, 32'h8000_0000));
        directed_rows.push_back(row(1'b0, 32'hFFFF_FFFF, 32'd1));
        directed_rows.push_back(row(1'b0, 32'd1, 32'hFFFF_FFFF));
        directed_rows.push_back(row(1'b0, 32'd65536, 32'd124518));
        directed_rows.push_back(row(1'b0, -32'sd65536, 32'd124519));
        directed_rows.push_back(row(1'b0, 32'd32768, 32'd0));
        directed_rows.push_back(row(1'b0, 32'd257, 32'd0));
        // Small decisions after the dwell count allow zoom-ins.
        for (int i = 0; i < 8; i++)
            directed_rows.push_back(row(1'b0, 32'd1000 * i, 32'd10));
        directed_rows.push_back(row(1'b1, 32'd0, 32'd0));
        directed_rows.push_back(row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA));

        foreach (directed_rows[i]) begin
            typed_flags.push_back(directed_rows[i].known);
            if (directed_rows[i].known) typed_results.push_back(directed_rows[i].result);
            send_beat(directed_rows[i].beat);
        end
        end_burst();
        drain();

        // Register settings: lower extremes (fallback bits, zero full scale, zero factors,
        // limits and thresholds), upper extremes, widest quantizer, one bit, 17 bits, random.
        settings.push_back('{5'd0, 32'd0, 18'd0, 18'd0, 48'd0, 48'd0, 16'd0, 16'd0});
        settings.push_back('{5'd31, 32'hFFFF_FFFF, 18'h3FFFF, 18'h3FFFF,
                             48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF});
        settings.push_back('{5'd16, 32'd65536, 18'd32768, 18'd131072,
                             48'd17, 48'd16777216000000, 16'd6554, 16'd0});
        settings.push_back('{5'd1, 32'd1, 18'd65536, 18'd262143,
                             48'd1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'd1});
        settings.push_back('{5'd17, 32'd200000, 18'd16384, 18'd98304,
                             48'd1 << 20, 48'd1 << 28, 16'd20000, 16'd2});
        for (int i = 0; i < 3; i++) begin
            c.quant_bits = 5'($urandom_range(31));
            c.full_scale = $urandom_range(3) == 0 ? $urandom() : $urandom_range(1, 1 << 20);
            c.shrink_factor = 18'($urandom_range(1 << 16, 16384));
            c.grow_factor = 18'($urandom_range(1 << 16, 262143));
            c.scale_floor = 48'($urandom_range(1 << 22));
            c.scale_ceiling = {16'($urandom()), 32'($urandom())};
            c.zoom_in_fraction = 16'($urandom());
            c.dwell_steps = 16'($urandom_range(6));
            settings.push_back(c);
        end
        // Return to the reset settings at the end.
        settings.push_back('{RST_QUANT_BITS, RST_FULL_SCALE, RST_SHRINK, RST_GROW,
                             RST_FLOOR, RST_CEILING, RST_ZI_FRAC, RST_DWELL});

        foreach (settings[p]) begin
            load_settings(settings[p]);
            // Cycle through the idle patterns: none, sender, receiver, both.
            phase = p % 4;
            sender_idle_pct = (phase == 1) ? 87 : (phase == 3) ? 16 : 0;
            receiver_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 16 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_beat(random_beat());
                // Occasionally hold off until the block has returned everything.
                if ($urandom_range(49) == 0) begin
                    end_burst();
                    drain();
                end
            end
            end_burst();
            drain();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
